// ===== rtl/mfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLP forward pass package
// Shared constants, request codes and the control word that travels from the
// sequencer through the multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
package mfp_pkg;

   // Fixed field widths of the request, result and register ports.
   localparam int VALUE_W      = 16;
   localparam int ACT_W        = 15;
   localparam int OP_W         = 2;
   localparam int LAYER_W      = 2;
   localparam int NEURON_W     = 4;
   localparam int OUT_INDEX_W  = 4;
   localparam int LCOUNT_W     = 3;
   localparam int CSR_DATA_W   = 5;
   localparam int CSR_INDEX_W  = 3;
   localparam int PROD_W       = 2 * VALUE_W;

   // Q4.12 arithmetic.
   localparam int FRAC_BITS    = 12;
   localparam int ACT_MAX      = 32767;

   // Layers whose width comes from a register; deeper layers use the full width.
   localparam int NUM_WIDTH_REGS = 4;

   // Cycles between the last read of a layer and the first read of the next,
   // so that the final write-back of the layer has landed in the store.
   localparam int DRAIN_CYCLES = 4;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_WEIGHT = 2'd0,
      OP_BIAS   = 2'd1,
      OP_ACT    = 2'd2
   } mfp_op_type;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYER_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LAYER0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LAYER1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LAYER2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LAYER3 = 3'd4;

   // Control word of one multiply-accumulate beat.
   typedef struct packed {
      logic valid;      // beat carries a product
      logic first;      // first source of a neuron: accumulator starts at the bias
      logic acc_done;   // last source of a neuron: result is ready afterward
      logic nrn_last;   // last neuron of the layer
      logic is_output;  // layer is the final layer
   } mfp_ctl_type;

   // Address width for a store of the given depth, at least one bit.
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mfp_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLP weight, bias and activation stores
// Three single-port-write memories with registered reads. Requests write
// weights, biases and input activations; the pipeline writes computed
// activations back.
// ----------------------------------------------------------------------------
module mfp_store #(
   parameter int MAX_LAYERS  = 4,
   parameter int MAX_NEURONS = 16
) (
   input  wire  logic                                  clock,
   // Request write side.
   input  wire  logic                                  req_write,
   input  wire  logic [mfp_pkg::OP_W-1:0]              req_operation,
   input  wire  logic [mfp_pkg::LAYER_W-1:0]           req_layer,
   input  wire  logic [mfp_pkg::NEURON_W-1:0]          req_neuron,
   input  wire  logic [mfp_pkg::NEURON_W-1:0]          req_source,
   input  wire  logic signed [mfp_pkg::VALUE_W-1:0]    req_value,
   // Read side, data in the cycle after the address.
   input  wire  logic [mfp_pkg::addr_bits((MAX_LAYERS-1)*MAX_NEURONS*MAX_NEURONS)-1:0]
                                                       wt_raddr_i,
   input  wire  logic [mfp_pkg::addr_bits((MAX_LAYERS-1)*MAX_NEURONS)-1:0] bias_raddr_i,
   input  wire  logic [mfp_pkg::addr_bits(MAX_LAYERS*MAX_NEURONS)-1:0]     act_raddr_i,
   output logic signed [mfp_pkg::VALUE_W-1:0]          wt_q_o,
   output logic signed [mfp_pkg::VALUE_W-1:0]          bias_q_o,
   output logic signed [mfp_pkg::VALUE_W-1:0]          act_q_o,
   // Computed activation write-back.
   input  wire  logic                                  wb_valid_i,
   input  wire  logic [mfp_pkg::addr_bits(MAX_LAYERS*MAX_NEURONS)-1:0]     wb_addr_i,
   input  wire  logic [mfp_pkg::ACT_W-1:0]             wb_value_i
);

   localparam int WT_DEPTH   = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
   localparam int BIAS_DEPTH = (MAX_LAYERS - 1) * MAX_NEURONS;
   localparam int ACT_DEPTH  = MAX_LAYERS * MAX_NEURONS;
   localparam int WA_W       = mfp_pkg::addr_bits(WT_DEPTH);
   localparam int BA_W       = mfp_pkg::addr_bits(BIAS_DEPTH);
   localparam int AA_W       = mfp_pkg::addr_bits(ACT_DEPTH);

   logic [mfp_pkg::VALUE_W-1:0] wt_mem   [WT_DEPTH];
   logic [mfp_pkg::VALUE_W-1:0] bias_mem [BIAS_DEPTH];
   logic [mfp_pkg::VALUE_W-1:0] act_mem  [ACT_DEPTH];

   logic              target_ok;
   logic              wt_we;
   logic              bias_we;
   logic              act_we;
   logic [WA_W-1:0]   wt_waddr;
   logic [BA_W-1:0]   bias_waddr;
   logic [AA_W-1:0]   act_waddr;
   logic [mfp_pkg::VALUE_W-1:0] act_wdata;

   // Decode the request: a write outside the stores is dropped.
   always_comb begin
      target_ok = (req_layer != '0) && (int'(req_layer) < MAX_LAYERS) &&
                  (int'(req_neuron) < MAX_NEURONS);
      wt_we     = req_write && (req_operation == mfp_pkg::OP_WEIGHT) && target_ok &&
                  (int'(req_source) < MAX_NEURONS);
      bias_we   = req_write && (req_operation == mfp_pkg::OP_BIAS) && target_ok;
      wt_waddr  = WA_W'(((int'(req_layer) - 1) * MAX_NEURONS + int'(req_neuron)) *
                        MAX_NEURONS + int'(req_source));
      bias_waddr = BA_W'((int'(req_layer) - 1) * MAX_NEURONS + int'(req_neuron));
   end

   // The activation store takes input activations while idle and results
   // while a run is in progress; the two never meet.
   always_comb begin
      if (wb_valid_i) begin
         act_we    = 1'b1;
         act_waddr = wb_addr_i;
         act_wdata = mfp_pkg::VALUE_W'(wb_value_i);
      end else begin
         act_we    = req_write && (req_operation == mfp_pkg::OP_ACT) &&
                     (int'(req_neuron) < MAX_NEURONS);
         act_waddr = AA_W'(req_neuron);
         act_wdata = req_value;
      end
   end

   // Weight memory.
   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[wt_waddr] <= req_value;
      end
      wt_q_o <= wt_mem[wt_raddr_i];
   end

   // Bias memory.
   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_mem[bias_waddr] <= req_value;
      end
      bias_q_o <= bias_mem[bias_raddr_i];
   end

   // Activation memory.
   always_ff @(posedge clock) begin
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
      act_q_o <= act_mem[act_raddr_i];
   end

endmodule
`default_nettype wire

// ===== rtl/mfp_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLP multiply-accumulate unit
// The one shared arithmetic unit: multiply register, wide accumulator that
// starts at the scaled bias, and a ReLU with saturation on each neuron's sum.
// ----------------------------------------------------------------------------
module mfp_mac #(
   parameter int MAX_LAYERS  = 4,
   parameter int MAX_NEURONS = 16
) (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   // Beat issued by the sequencer in the cycle before the store data.
   input  wire  mfp_pkg::mfp_ctl_type                  ctl_i,
   input  wire  logic [mfp_pkg::addr_bits(MAX_LAYERS*MAX_NEURONS)-1:0] wb_addr_i,
   input  wire  logic [mfp_pkg::addr_bits(MAX_NEURONS)-1:0]            nrn_i,
   input  wire  logic signed [mfp_pkg::VALUE_W-1:0]    wt_q_i,
   input  wire  logic signed [mfp_pkg::VALUE_W-1:0]    bias_q_i,
   input  wire  logic signed [mfp_pkg::VALUE_W-1:0]    act_q_i,
   // Finished neuron.
   output mfp_pkg::mfp_ctl_type                        res_ctl_o,
   output logic [mfp_pkg::addr_bits(MAX_LAYERS*MAX_NEURONS)-1:0]       res_addr_o,
   output logic [mfp_pkg::addr_bits(MAX_NEURONS)-1:0]  res_nrn_o,
   output logic [mfp_pkg::ACT_W-1:0]                   res_value_o
);

   localparam int NB    = mfp_pkg::addr_bits(MAX_NEURONS);
   localparam int AA_W  = mfp_pkg::addr_bits(MAX_LAYERS * MAX_NEURONS);
   localparam int ACC_W = mfp_pkg::PROD_W + NB + 1;

   // Stage 1: aligned with the registered store reads.
   mfp_pkg::mfp_ctl_type ctl1_ff, ctl1_in;
   logic [AA_W-1:0]      addr1_ff;
   logic [NB-1:0]        nrn1_ff;
   // Stage 2: product and bias.
   mfp_pkg::mfp_ctl_type ctl2_ff, ctl2_in;
   logic [AA_W-1:0]      addr2_ff;
   logic [NB-1:0]        nrn2_ff;
   logic signed [mfp_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [mfp_pkg::VALUE_W-1:0] bias2_ff;
   // Stage 3: accumulator.
   mfp_pkg::mfp_ctl_type ctl3_ff, ctl3_in;
   logic [AA_W-1:0]      addr3_ff;
   logic [NB-1:0]        nrn3_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   // Stage 4: result.
   mfp_pkg::mfp_ctl_type res_ctl_ff, res_ctl_in;
   logic [mfp_pkg::ACT_W-1:0] res_value_ff, res_value_in;
   logic [AA_W-1:0]      res_addr_ff;
   logic [NB-1:0]        res_nrn_ff;

   logic signed [ACC_W-1:0] bias_scaled;
   logic signed [ACC_W-1:0] acc_shifted;

   // Multiply the two operands as they come out of the stores.
   always_comb begin
      ctl1_in = ctl_i;
      ctl2_in = ctl1_ff;
      ctl3_in = ctl2_ff;
      prod_in = mfp_pkg::PROD_W'(act_q_i) * mfp_pkg::PROD_W'(wt_q_i);
   end

   // Accumulate; the first source of a neuron restarts from the bias in Q8.24.
   always_comb begin
      bias_scaled = ACC_W'(bias2_ff) <<< mfp_pkg::FRAC_BITS;
      acc_in      = acc_ff;
      if (ctl2_ff.valid) begin
         acc_in = (ctl2_ff.first ? bias_scaled : acc_ff) + ACC_W'(prod_ff);
      end
   end

   // ReLU, truncate to Q4.12 and saturate.
   always_comb begin
      acc_shifted  = acc_ff >>> mfp_pkg::FRAC_BITS;
      res_ctl_in   = ctl3_ff;
      res_ctl_in.valid = ctl3_ff.valid && ctl3_ff.acc_done;
      if (acc_ff[ACC_W-1] || (acc_ff == '0)) begin
         res_value_in = '0;
      end else if (acc_shifted > ACC_W'(mfp_pkg::ACT_MAX)) begin
         res_value_in = mfp_pkg::ACT_W'(mfp_pkg::ACT_MAX);
      end else begin
         res_value_in = mfp_pkg::ACT_W'(acc_shifted);
      end
   end

   // Control flags of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff    <= '0;
         ctl2_ff    <= '0;
         ctl3_ff    <= '0;
         res_ctl_ff <= '0;
      end else begin
         ctl1_ff    <= ctl1_in;
         ctl2_ff    <= ctl2_in;
         ctl3_ff    <= ctl3_in;
         res_ctl_ff <= res_ctl_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      addr1_ff     <= wb_addr_i;
      nrn1_ff      <= nrn_i;
      addr2_ff     <= addr1_ff;
      nrn2_ff      <= nrn1_ff;
      prod_ff      <= prod_in;
      bias2_ff     <= bias_q_i;
      addr3_ff     <= addr2_ff;
      nrn3_ff      <= nrn2_ff;
      acc_ff       <= acc_in;
      res_addr_ff  <= addr3_ff;
      res_nrn_ff   <= nrn3_ff;
      res_value_ff <= res_value_in;
   end

   assign res_ctl_o   = res_ctl_ff;
   assign res_addr_o  = res_addr_ff;
   assign res_nrn_o   = res_nrn_ff;
   assign res_value_o = res_value_ff;

   // Sources of one neuron arrive back to back.
   a_sources_contiguous: assert property (@(posedge clock) disable iff (reset)
      (ctl2_ff.valid && !ctl2_ff.first) |-> $past(ctl2_ff.valid))
      else $error("Accumulation beat without a preceding beat.");

   // After a neuron's last source, the next beat restarts the accumulator.
   a_restart_after_done: assert property (@(posedge clock) disable iff (reset)
      (ctl3_ff.valid && ctl3_ff.acc_done) |=> (!ctl3_ff.valid || ctl3_ff.first))
      else $error("Neuron accumulation did not restart from its bias.");

endmodule
`default_nettype wire

// ===== rtl/mfp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLP sequencer
// Walks layers, neurons and sources, one multiply-accumulate beat per cycle,
// and waits for the last write-back of a layer before starting the next.
// ----------------------------------------------------------------------------
module mfp_seq #(
   parameter int MAX_LAYERS  = 4,
   parameter int MAX_NEURONS = 16
) (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   input  wire  logic                                  start_run_i,
   input  wire  logic [mfp_pkg::addr_bits(MAX_LAYERS)-1:0] layer_last_i,
   input  wire  logic [MAX_LAYERS-1:0][mfp_pkg::addr_bits(MAX_NEURONS)-1:0] width_last_i,
   output logic                                        busy_o,
   output mfp_pkg::mfp_ctl_type                        ctl_o,
   output logic [mfp_pkg::addr_bits((MAX_LAYERS-1)*MAX_NEURONS*MAX_NEURONS)-1:0]
                                                       wt_raddr_o,
   output logic [mfp_pkg::addr_bits((MAX_LAYERS-1)*MAX_NEURONS)-1:0] bias_raddr_o,
   output logic [mfp_pkg::addr_bits(MAX_LAYERS*MAX_NEURONS)-1:0]     act_raddr_o,
   output logic [mfp_pkg::addr_bits(MAX_LAYERS*MAX_NEURONS)-1:0]     wb_addr_o,
   output logic [mfp_pkg::addr_bits(MAX_NEURONS)-1:0]  nrn_o
);

   localparam int NB   = mfp_pkg::addr_bits(MAX_NEURONS);
   localparam int LB   = mfp_pkg::addr_bits(MAX_LAYERS);
   localparam int WA_W = mfp_pkg::addr_bits((MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS);
   localparam int BA_W = mfp_pkg::addr_bits((MAX_LAYERS - 1) * MAX_NEURONS);
   localparam int AA_W = mfp_pkg::addr_bits(MAX_LAYERS * MAX_NEURONS);
   localparam logic [mfp_pkg::DRAIN_W-1:0] DRAIN_LAST =
      mfp_pkg::DRAIN_W'(mfp_pkg::DRAIN_CYCLES - 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ISSUE = 3'b010,
      S_DRAIN = 3'b100
   } mfp_state_type;

   mfp_state_type state_ff, state_in;
   logic [LB-1:0]  layer_ff, layer_in;
   logic [NB-1:0]  nrn_ff, nrn_in;
   logic [NB-1:0]  src_ff, src_in;
   logic [mfp_pkg::DRAIN_W-1:0] drain_ff, drain_in;

   logic [LB-1:0]  prev_layer;
   logic           src_last;
   logic           nrn_last;
   logic           out_layer;

   // Position within the run.
   always_comb begin
      prev_layer = layer_ff - LB'(1);
      src_last   = (src_ff == width_last_i[prev_layer]);
      nrn_last   = (nrn_ff == width_last_i[layer_ff]);
      out_layer  = (layer_ff == layer_last_i);
   end

   // Store addresses of the current beat.
   always_comb begin
      act_raddr_o  = AA_W'(int'(prev_layer) * MAX_NEURONS + int'(src_ff));
      bias_raddr_o = BA_W'(int'(prev_layer) * MAX_NEURONS + int'(nrn_ff));
      wt_raddr_o   = WA_W'((int'(prev_layer) * MAX_NEURONS + int'(nrn_ff)) * MAX_NEURONS +
                           int'(src_ff));
      wb_addr_o    = AA_W'(int'(layer_ff) * MAX_NEURONS + int'(nrn_ff));
      nrn_o        = nrn_ff;
   end

   // Control word of the current beat.
   always_comb begin
      ctl_o.valid     = (state_ff == S_ISSUE);
      ctl_o.first     = (src_ff == '0);
      ctl_o.acc_done  = src_last;
      ctl_o.nrn_last  = nrn_last;
      ctl_o.is_output = out_layer;
   end

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      nrn_in   = nrn_ff;
      src_in   = src_ff;
      drain_in = drain_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start_run_i) begin
               state_in = S_ISSUE;
               layer_in = LB'(1);
               nrn_in   = '0;
               src_in   = '0;
            end
         end
         S_ISSUE: begin
            if (src_last) begin
               src_in = '0;
               if (nrn_last) begin
                  nrn_in   = '0;
                  drain_in = '0;
                  state_in = S_DRAIN;
               end else begin
                  nrn_in = nrn_ff + NB'(1);
               end
            end else begin
               src_in = src_ff + NB'(1);
            end
         end
         S_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               if (out_layer) begin
                  state_in = S_IDLE;
               end else begin
                  layer_in = layer_ff + LB'(1);
                  state_in = S_ISSUE;
               end
            end else begin
               drain_in = drain_ff + mfp_pkg::DRAIN_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         layer_ff <= LB'(1);
         nrn_ff   <= '0;
         src_ff   <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         nrn_ff   <= nrn_in;
         src_ff   <= src_in;
         drain_ff <= drain_in;
      end
   end

   assign busy_o = (state_ff != S_IDLE);

   // A run request in idle starts issuing on the next cycle.
   a_start_issues: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && start_run_i) |=> (state_ff == S_ISSUE))
      else $error("Run request did not start issuing.");

   // The drain after the final layer ends the run.
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && drain_ff == DRAIN_LAST && out_layer) |=> !busy_o)
      else $error("Run did not end after the final layer.");

endmodule
`default_nettype wire

// ===== rtl/mlp_forward_pass_relu_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MLP forward pass with ReLU
// Fully connected Q4.12 inference over weight, bias and activation stores,
// computed on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A weight, bias or plain input-activation request leaves busy low. An input
// activation with req_last set starts a run and raises busy: the single
// multiply-accumulate unit takes one source per cycle, and each layer waits
// for its last write-back to reach the activation memory before the next
// layer starts. The final layer's activations appear on rsp_strobe in neuron
// order, one per row of sources, while the run is in progress; they cannot
// be held off and must be taken on the cycle they appear. Requests are taken
// only while busy is low. Configuration must be written only while busy is
// low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mlp_forward_pass_relu_core #(
   parameter int MAX_LAYERS  = 4,
   parameter int MAX_NEURONS = 16
) (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   // Request channel.
   input  wire  logic                                  start,
   output logic                                        busy,
   input  wire  logic [mfp_pkg::OP_W-1:0]              req_operation,
   input  wire  logic [mfp_pkg::LAYER_W-1:0]           req_layer,
   input  wire  logic [mfp_pkg::NEURON_W-1:0]          req_neuron,
   input  wire  logic [mfp_pkg::NEURON_W-1:0]          req_source,
   input  wire  logic signed [mfp_pkg::VALUE_W-1:0]    req_value,
   input  wire  logic                                  req_last,
   // Result channel.
   output logic                                        rsp_strobe,
   output logic [mfp_pkg::OUT_INDEX_W-1:0]             rsp_out_index,
   output logic [mfp_pkg::ACT_W-1:0]                   rsp_out_activation,
   output logic                                        rsp_out_last,
   // Configuration port.
   input  wire  logic                                  csr_write_en,
   input  wire  logic [mfp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  logic [mfp_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int NB   = mfp_pkg::addr_bits(MAX_NEURONS);
   localparam int LB   = mfp_pkg::addr_bits(MAX_LAYERS);
   localparam int WA_W = mfp_pkg::addr_bits((MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS);
   localparam int BA_W = mfp_pkg::addr_bits((MAX_LAYERS - 1) * MAX_NEURONS);
   localparam int AA_W = mfp_pkg::addr_bits(MAX_LAYERS * MAX_NEURONS);

   logic [mfp_pkg::LCOUNT_W-1:0] layer_count_ff, layer_count_in;
   logic [mfp_pkg::NUM_WIDTH_REGS-1:0][mfp_pkg::CSR_DATA_W-1:0] width_ff, width_in;

   logic [LB-1:0]                     layer_last;
   logic [MAX_LAYERS-1:0][NB-1:0]     width_last;

   logic                  req_accept;
   logic                  start_run;
   mfp_pkg::mfp_ctl_type  issue_ctl;
   mfp_pkg::mfp_ctl_type  res_ctl;
   logic [WA_W-1:0]       wt_raddr;
   logic [BA_W-1:0]       bias_raddr;
   logic [AA_W-1:0]       act_raddr;
   logic [AA_W-1:0]       issue_wb_addr;
   logic [NB-1:0]         issue_nrn;
   logic signed [mfp_pkg::VALUE_W-1:0] wt_q;
   logic signed [mfp_pkg::VALUE_W-1:0] bias_q;
   logic signed [mfp_pkg::VALUE_W-1:0] act_q;
   logic [AA_W-1:0]       res_addr;
   logic [NB-1:0]         res_nrn;
   logic [mfp_pkg::ACT_W-1:0] res_value;

   // Configuration register writes.
   always_comb begin
      layer_count_in = layer_count_ff;
      width_in       = width_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            mfp_pkg::CSR_LAYER_COUNT:  layer_count_in = mfp_pkg::LCOUNT_W'(csr_data);
            mfp_pkg::CSR_WIDTH_LAYER0: width_in[0]    = csr_data;
            mfp_pkg::CSR_WIDTH_LAYER1: width_in[1]    = csr_data;
            mfp_pkg::CSR_WIDTH_LAYER2: width_in[2]    = csr_data;
            mfp_pkg::CSR_WIDTH_LAYER3: width_in[3]    = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= mfp_pkg::LCOUNT_W'(2);
         width_ff       <= {mfp_pkg::NUM_WIDTH_REGS{mfp_pkg::CSR_DATA_W'(16)}};
      end else begin
         layer_count_ff <= layer_count_in;
         width_ff       <= width_in;
      end
   end

   // Clamp the layer count to 2 .. MAX_LAYERS, held as the final layer index.
   always_comb begin
      if (layer_count_ff < mfp_pkg::LCOUNT_W'(2)) begin
         layer_last = LB'(1);
      end else if (int'(layer_count_ff) > MAX_LAYERS) begin
         layer_last = LB'(MAX_LAYERS - 1);
      end else begin
         layer_last = LB'(layer_count_ff - mfp_pkg::LCOUNT_W'(1));
      end
   end

   // Clamp each width to 1 .. MAX_NEURONS, held as the last neuron index.
   for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_width
      if (g < mfp_pkg::NUM_WIDTH_REGS) begin : g_reg
         always_comb begin
            if (width_ff[g] == '0) begin
               width_last[g] = '0;
            end else if (int'(width_ff[g]) > MAX_NEURONS) begin
               width_last[g] = NB'(MAX_NEURONS - 1);
            end else begin
               width_last[g] = NB'(width_ff[g] - mfp_pkg::CSR_DATA_W'(1));
            end
         end
      end else begin : g_full
         assign width_last[g] = NB'(MAX_NEURONS - 1);
      end
   end

   // Request acceptance; the last input activation starts a run.
   always_comb begin
      req_accept = start && !busy;
      start_run  = req_accept && (req_operation == mfp_pkg::OP_ACT) && req_last;
   end

   mfp_seq #(
      .MAX_LAYERS  (MAX_LAYERS),
      .MAX_NEURONS (MAX_NEURONS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start_run_i  (start_run),
      .layer_last_i (layer_last),
      .width_last_i (width_last),
      .busy_o       (busy),
      .ctl_o        (issue_ctl),
      .wt_raddr_o   (wt_raddr),
      .bias_raddr_o (bias_raddr),
      .act_raddr_o  (act_raddr),
      .wb_addr_o    (issue_wb_addr),
      .nrn_o        (issue_nrn)
   );

   mfp_store #(
      .MAX_LAYERS  (MAX_LAYERS),
      .MAX_NEURONS (MAX_NEURONS)
   ) u_store (
      .clock         (clock),
      .req_write     (req_accept),
      .req_operation (req_operation),
      .req_layer     (req_layer),
      .req_neuron    (req_neuron),
      .req_source    (req_source),
      .req_value     (req_value),
      .wt_raddr_i    (wt_raddr),
      .bias_raddr_i  (bias_raddr),
      .act_raddr_i   (act_raddr),
      .wt_q_o        (wt_q),
      .bias_q_o      (bias_q),
      .act_q_o       (act_q),
      .wb_valid_i    (res_ctl.valid),
      .wb_addr_i     (res_addr),
      .wb_value_i    (res_value)
   );

   mfp_mac #(
      .MAX_LAYERS  (MAX_LAYERS),
      .MAX_NEURONS (MAX_NEURONS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctl_i       (issue_ctl),
      .wb_addr_i   (issue_wb_addr),
      .nrn_i       (issue_nrn),
      .wt_q_i      (wt_q),
      .bias_q_i    (bias_q),
      .act_q_i     (act_q),
      .res_ctl_o   (res_ctl),
      .res_addr_o  (res_addr),
      .res_nrn_o   (res_nrn),
      .res_value_o (res_value)
   );

   // Final-layer neurons go straight out as they finish.
   always_comb begin
      rsp_strobe         = res_ctl.valid && res_ctl.is_output;
      rsp_out_index      = mfp_pkg::OUT_INDEX_W'(res_nrn);
      rsp_out_activation = res_value;
      rsp_out_last       = res_ctl.nrn_last;
   end

   // Results only come out during a run.
   a_result_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("Result strobe outside a run.");

endmodule
`default_nettype wire

// ===== tb/sv/mlp_forward_pass_relu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLP forward pass result checker
// Follows accepted requests and register writes to keep its own copy of the
// weight, bias and activation stores and of the layer registers. On every
// request that starts an inference run it recomputes the network and queues
// the final layer's activations. Each strobed result is compared field by
// field with the oldest queued activation.
// ----------------------------------------------------------------------------
module mlp_forward_pass_relu_checker #(
   parameter int MAX_LAYERS  = 4,
   parameter int MAX_NEURONS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Request channel.
   input  logic                                    start,
   input  logic                                    busy,
   input  logic [mfp_pkg::OP_W-1:0]                req_operation,
   input  logic [mfp_pkg::LAYER_W-1:0]             req_layer,
   input  logic [mfp_pkg::NEURON_W-1:0]            req_neuron,
   input  logic [mfp_pkg::NEURON_W-1:0]            req_source,
   input  logic signed [mfp_pkg::VALUE_W-1:0]      req_value,
   input  logic                                    req_last,
   // Result channel.
   input  logic                                    rsp_strobe,
   input  logic [mfp_pkg::OUT_INDEX_W-1:0]         rsp_out_index,
   input  logic [mfp_pkg::ACT_W-1:0]               rsp_out_activation,
   input  logic                                    rsp_out_last,
   // Configuration port.
   input  logic                                    csr_write_en,
   input  logic [mfp_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [mfp_pkg::CSR_DATA_W-1:0]          csr_data,
   // Status toward the testbench top.
   output int                                      mismatch_count,
   output int                                      pending_count
);

   // One activation of the final layer as it should leave the block.
   typedef struct packed {
      logic [mfp_pkg::OUT_INDEX_W-1:0] nrn;
      logic [mfp_pkg::ACT_W-1:0]       act_val;
      logic                            is_last;
   } neuron_result_type;

   logic signed [mfp_pkg::VALUE_W-1:0] weight_mem [MAX_LAYERS-1][MAX_NEURONS][MAX_NEURONS];
   logic signed [mfp_pkg::VALUE_W-1:0] bias_mem   [MAX_LAYERS-1][MAX_NEURONS];
   logic signed [mfp_pkg::VALUE_W-1:0] act_mem    [MAX_LAYERS][MAX_NEURONS];

   logic [mfp_pkg::LCOUNT_W-1:0]   layer_count_reg;
   logic [mfp_pkg::CSR_DATA_W-1:0] width_regs [mfp_pkg::NUM_WIDTH_REGS];

   neuron_result_type expected_outputs [$];
   neuron_result_type oldest;

   // Layer count in use, clamped to the supported range.
   function automatic int layers_in_use();
      int n;
      n = layer_count_reg;
      if (n < 2) n = 2;
      if (n > MAX_LAYERS) n = MAX_LAYERS;
      return n;
   endfunction

   // Width of one layer, clamped to 1 .. MAX_NEURONS; deep layers are full.
   function automatic int layer_width(input int l);
      int w;
      if (l >= mfp_pkg::NUM_WIDTH_REGS) return MAX_NEURONS;
      w = width_regs[l];
      if (w < 1) w = 1;
      if (w > MAX_NEURONS) w = MAX_NEURONS;
      return w;
   endfunction

   // Computes every layer after the input layer and queues the final layer.
   function automatic void forward_pass();
      int                n_layers;
      int                prev_w;
      int                cur_w;
      longint            acc;
      longint            a;
      longint            w;
      longint            b;
      neuron_result_type res;
      n_layers = layers_in_use();
      for (int l = 1; l < n_layers; l++) begin
         prev_w = layer_width(l - 1);
         cur_w  = layer_width(l);
         for (int n = 0; n < cur_w; n++) begin
            acc = 0;
            for (int s = 0; s < prev_w; s++) begin
               a = act_mem[l-1][s];
               w = weight_mem[l-1][n][s];
               acc += a * w;
            end
            b = bias_mem[l-1][n];
            acc += b <<< mfp_pkg::FRAC_BITS;
            // ReLU, then back to Q4.12 by truncation with saturation.
            if (acc <= 0) begin
               acc = 0;
            end else begin
               acc = acc >>> mfp_pkg::FRAC_BITS;
               if (acc > mfp_pkg::ACT_MAX) acc = mfp_pkg::ACT_MAX;
            end
            act_mem[l][n] = mfp_pkg::VALUE_W'(acc);
         end
      end
      cur_w = layer_width(n_layers - 1);
      for (int n = 0; n < cur_w; n++) begin
         res.nrn     = mfp_pkg::OUT_INDEX_W'(n);
         res.act_val = act_mem[n_layers-1][n][mfp_pkg::ACT_W-1:0];
         res.is_last = (n == cur_w - 1);
         expected_outputs.push_back(res);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         layer_count_reg = mfp_pkg::LCOUNT_W'(2);
         for (int i = 0; i < mfp_pkg::NUM_WIDTH_REGS; i++)
            width_regs[i] = mfp_pkg::CSR_DATA_W'(MAX_NEURONS);
         expected_outputs.delete();
      end else begin
         // Results leave in order and cannot be held off.
         if (rsp_strobe) begin
            if (expected_outputs.size() == 0) begin
               $display("%0t: result with none expected: index %0d activation %0d last %0d",
                        $time, rsp_out_index, rsp_out_activation, rsp_out_last);
               mismatch_count++;
            end else begin
               oldest = expected_outputs.pop_front();
               if (rsp_out_index !== oldest.nrn) begin
                  $display("%0t: rsp_out_index expected %0d, got %0d",
                           $time, oldest.nrn, rsp_out_index);
                  mismatch_count++;
               end
               if (rsp_out_activation !== oldest.act_val) begin
                  $display("%0t: rsp_out_activation of neuron %0d expected %0d, got %0d",
                           $time, oldest.nrn, oldest.act_val, rsp_out_activation);
                  mismatch_count++;
               end
               if (rsp_out_last !== oldest.is_last) begin
                  $display("%0t: rsp_out_last of neuron %0d expected %0d, got %0d",
                           $time, oldest.nrn, oldest.is_last, rsp_out_last);
                  mismatch_count++;
               end
            end
         end

         // Register writes; indexes past the last width register do nothing.
         if (csr_write_en) begin
            case (csr_index)
               mfp_pkg::CSR_LAYER_COUNT:
                  layer_count_reg = csr_data[mfp_pkg::LCOUNT_W-1:0];
               mfp_pkg::CSR_WIDTH_LAYER0: width_regs[0] = csr_data;
               mfp_pkg::CSR_WIDTH_LAYER1: width_regs[1] = csr_data;
               mfp_pkg::CSR_WIDTH_LAYER2: width_regs[2] = csr_data;
               mfp_pkg::CSR_WIDTH_LAYER3: width_regs[3] = csr_data;
               default: ;
            endcase
         end

         // An accepted request updates the stores and may start a run.
         if (start && !busy) begin
            case (req_operation)
               mfp_pkg::OP_WEIGHT: begin
                  if (req_layer >= 1 && int'(req_layer) < MAX_LAYERS &&
                      int'(req_neuron) < MAX_NEURONS && int'(req_source) < MAX_NEURONS)
                     weight_mem[int'(req_layer) - 1][req_neuron][req_source] = req_value;
               end
               mfp_pkg::OP_BIAS: begin
                  if (req_layer >= 1 && int'(req_layer) < MAX_LAYERS &&
                      int'(req_neuron) < MAX_NEURONS)
                     bias_mem[int'(req_layer) - 1][req_neuron] = req_value;
               end
               mfp_pkg::OP_ACT: begin
                  if (int'(req_neuron) < MAX_NEURONS) act_mem[0][req_neuron] = req_value;
                  if (req_last) forward_pass();
               end
               default: ;
            endcase
         end
      end
      pending_count <= expected_outputs.size();
   end

endmodule

// ===== tb/sv/mlp_forward_pass_relu_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLP forward pass testbench
// Drives weight, bias and input activation requests and register writes into
// the core, with a directed opening and then random phases over several layer
// settings. Before every inference run all weights, biases and inputs that the
// run reads are loaded. A separate checker predicts and compares the results;
// this module only makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module mlp_forward_pass_relu_core_tb;

   localparam int MAX_LAYERS    = 4;
   localparam int MAX_NEURONS   = 16;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDLE_PERCENT  = 18;

   // Operation code that the core ignores.
   localparam logic [mfp_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [mfp_pkg::OP_W-1:0]            req_operation;
   logic [mfp_pkg::LAYER_W-1:0]         req_layer;
   logic [mfp_pkg::NEURON_W-1:0]        req_neuron;
   logic [mfp_pkg::NEURON_W-1:0]        req_source;
   logic signed [mfp_pkg::VALUE_W-1:0]  req_value;
   logic                                req_last;
   logic                                rsp_strobe;
   logic [mfp_pkg::OUT_INDEX_W-1:0]     rsp_out_index;
   logic [mfp_pkg::ACT_W-1:0]           rsp_out_activation;
   logic                                rsp_out_last;
   logic                                csr_write_en;
   logic [mfp_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [mfp_pkg::CSR_DATA_W-1:0]      csr_data;
   int                                  mismatch_count;
   int                                  pending_count;
   int                                  cycle_count;

   // Register values as written, and which store entries hold data.
   logic [mfp_pkg::CSR_DATA_W-1:0] cfg_raw [5];
   bit                    weight_loaded [MAX_LAYERS-1][MAX_NEURONS][MAX_NEURONS];
   bit                    bias_loaded   [MAX_LAYERS-1][MAX_NEURONS];
   bit                    input_loaded  [MAX_NEURONS];
   bit                    idle_enabled;

   mlp_forward_pass_relu_core #(
      .MAX_LAYERS  (MAX_LAYERS),
      .MAX_NEURONS (MAX_NEURONS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_layer          (req_layer),
      .req_neuron         (req_neuron),
      .req_source         (req_source),
      .req_value          (req_value),
      .req_last           (req_last),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_index      (rsp_out_index),
      .rsp_out_activation (rsp_out_activation),
      .rsp_out_last       (rsp_out_last),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   mlp_forward_pass_relu_checker #(
      .MAX_LAYERS  (MAX_LAYERS),
      .MAX_NEURONS (MAX_NEURONS)
   ) result_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_layer          (req_layer),
      .req_neuron         (req_neuron),
      .req_source         (req_source),
      .req_value          (req_value),
      .req_last           (req_last),
      .rsp_strobe         (rsp_strobe),
      .rsp_out_index      (rsp_out_index),
      .rsp_out_activation (rsp_out_activation),
      .rsp_out_last       (rsp_out_last),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Layer count in use, as the written register selects it.
   function automatic int used_layers();
      int n;
      n = cfg_raw[0][mfp_pkg::LCOUNT_W-1:0];
      if (n < 2) n = 2;
      if (n > MAX_LAYERS) n = MAX_LAYERS;
      return n;
   endfunction

   // Clamped width of a layer under the written registers.
   function automatic int used_width(input int l);
      int w;
      if (l >= mfp_pkg::NUM_WIDTH_REGS) return MAX_NEURONS;
      w = cfg_raw[l + 1];
      if (w < 1) w = 1;
      if (w > MAX_NEURONS) w = MAX_NEURONS;
      return w;
   endfunction

   // Mostly values within +/-1.0, with full-range values and the extremes mixed in.
   function automatic logic [mfp_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'h7FFF;
      if (r < 10) return 16'h8000;
      if (r < 13) return 16'h0000;
      if (r < 40) return mfp_pkg::VALUE_W'($urandom);
      return mfp_pkg::VALUE_W'($urandom_range(8191)) - 16'd4096;
   endfunction

   // Drives one request and returns at the edge that accepts it; start stays
   // high so that the next request can follow without a gap.
   task automatic issue(input logic [mfp_pkg::OP_W-1:0] op, input int lyr, input int nrn,
                        input int src, input logic [mfp_pkg::VALUE_W-1:0] val,
                        input bit lst);
      if (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_layer     <= mfp_pkg::LAYER_W'(lyr);
      req_neuron    <= mfp_pkg::NEURON_W'(nrn);
      req_source    <= mfp_pkg::NEURON_W'(src);
      req_value     <= val;
      req_last      <= lst;
      do @(posedge clock); while (busy);
      if (op == mfp_pkg::OP_WEIGHT && lyr >= 1) weight_loaded[lyr-1][nrn][src] = 1'b1;
      if (op == mfp_pkg::OP_BIAS && lyr >= 1) bias_loaded[lyr-1][nrn] = 1'b1;
      if (op == mfp_pkg::OP_ACT) input_loaded[nrn] = 1'b1;
   endtask

   // Drops start and waits until the core is idle with nothing outstanding.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all five layer registers while the core is idle.
   task automatic configure(input logic [mfp_pkg::CSR_DATA_W-1:0] lcount,
                            input logic [mfp_pkg::CSR_DATA_W-1:0] w0,
                            input logic [mfp_pkg::CSR_DATA_W-1:0] w1,
                            input logic [mfp_pkg::CSR_DATA_W-1:0] w2,
                            input logic [mfp_pkg::CSR_DATA_W-1:0] w3);
      logic [mfp_pkg::CSR_INDEX_W-1:0] reg_index [5];
      logic [mfp_pkg::CSR_DATA_W-1:0]  reg_value [5];
      settle();
      reg_index[0] = mfp_pkg::CSR_LAYER_COUNT;
      reg_index[1] = mfp_pkg::CSR_WIDTH_LAYER0;
      reg_index[2] = mfp_pkg::CSR_WIDTH_LAYER1;
      reg_index[3] = mfp_pkg::CSR_WIDTH_LAYER2;
      reg_index[4] = mfp_pkg::CSR_WIDTH_LAYER3;
      reg_value[0] = lcount;
      reg_value[1] = w0;
      reg_value[2] = w1;
      reg_value[3] = w2;
      reg_value[4] = w3;
      for (int i = 0; i < 5; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= reg_index[i];
         csr_data     <= reg_value[i];
         cfg_raw[i]   = reg_value[i];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // Loads every weight, bias and input that the next run reads and that
   // was never written, so that no run touches an empty store entry.
   task automatic prime_network();
      int lcount;
      lcount = used_layers();
      for (int l = 1; l < lcount; l++) begin
         for (int n = 0; n < used_width(l); n++) begin
            if (!bias_loaded[l-1][n])
               issue(mfp_pkg::OP_BIAS, l, n, $urandom_range(15), pick_value(), 0);
            for (int s = 0; s < used_width(l - 1); s++)
               if (!weight_loaded[l-1][n][s])
                  issue(mfp_pkg::OP_WEIGHT, l, n, s, pick_value(), 0);
         end
      end
      for (int s = 0; s < used_width(0); s++)
         if (!input_loaded[s]) issue(mfp_pkg::OP_ACT, 0, s, 0, pick_value(), 0);
   endtask

   // Random requests: mostly writes into the layers in use and inference
   // runs, with ignored requests mixed in that do not count.
   task automatic random_items(input int count);
      int done_items;
      int r;
      int l;
      int n;
      int s;
      done_items = 0;
      while (done_items < count) begin
         r = $urandom_range(99);
         if (r < 40) begin
            l = $urandom_range(used_layers() - 1, 1);
            n = $urandom_range(used_width(l) - 1);
            s = $urandom_range(used_width(l - 1) - 1);
            issue(mfp_pkg::OP_WEIGHT, l, n, s, pick_value(), $urandom_range(9) == 0);
            done_items++;
         end else if (r < 52) begin
            l = $urandom_range(used_layers() - 1, 1);
            n = $urandom_range(used_width(l) - 1);
            issue(mfp_pkg::OP_BIAS, l, n, $urandom_range(15), pick_value(),
                  $urandom_range(9) == 0);
            done_items++;
         end else if (r < 72) begin
            n = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(used_width(0) - 1);
            issue(mfp_pkg::OP_ACT, $urandom_range(3), n, $urandom_range(15), pick_value(), 0);
            done_items++;
         end else if (r < 86) begin
            prime_network();
            issue(mfp_pkg::OP_ACT, $urandom_range(3), $urandom_range(used_width(0) - 1),
                  $urandom_range(15), pick_value(), 1);
            done_items++;
         end else begin
            case ($urandom_range(2))
               0: issue(OP_RESERVED, $urandom_range(3), $urandom_range(15), $urandom_range(15),
                        pick_value(), $urandom_range(1));
               1: issue(($urandom_range(1) != 0) ? mfp_pkg::OP_BIAS : mfp_pkg::OP_WEIGHT, 0,
                        $urandom_range(15), $urandom_range(15), pick_value(),
                        $urandom_range(1));
               default: begin
                  // Any entry of any layer, used or not.
                  issue(mfp_pkg::OP_WEIGHT, $urandom_range(3, 1), $urandom_range(15),
                        $urandom_range(15), pick_value(), 0);
                  done_items++;
               end
            endcase
         end
      end
   endtask

   initial begin
      cfg_raw[0] = mfp_pkg::CSR_DATA_W'(2);
      for (int i = 1; i < 5; i++) cfg_raw[i] = mfp_pkg::CSR_DATA_W'(MAX_NEURONS);
      idle_enabled  = 1'b1;
      cycle_count   <= 0;
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= mfp_pkg::OP_WEIGHT;
      req_layer     <= '0;
      req_neuron    <= '0;
      req_source    <= '0;
      req_value     <= '0;
      req_last      <= 1'b0;
      csr_write_en  <= 1'b0;
      csr_index     <= mfp_pkg::CSR_LAYER_COUNT;
      csr_data      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Two inputs into two neurons, one extra layer.
      configure(5'd2, 5'd2, 5'd2, 5'd1, 5'd16);

      // A large positive sum saturates, a negative one clamps to zero.
      issue(mfp_pkg::OP_WEIGHT, 1, 0, 0, 16'h7FFF, 0);
      issue(mfp_pkg::OP_WEIGHT, 1, 0, 1, 16'h7FFF, 0);
      issue(mfp_pkg::OP_BIAS, 1, 0, 0, 16'h7FFF, 0);
      issue(mfp_pkg::OP_WEIGHT, 1, 1, 0, 16'h8000, 0);
      issue(mfp_pkg::OP_WEIGHT, 1, 1, 1, 16'h7FFF, 0);
      issue(mfp_pkg::OP_BIAS, 1, 1, 0, 16'h8000, 0);
      issue(mfp_pkg::OP_ACT, 0, 0, 0, 16'h7FFF, 0);
      issue(mfp_pkg::OP_ACT, 3, 1, 15, 16'h7FFF, 1);

      // Ignored requests: layer 0 targets, the unused operation code and the
      // last flag on weight or bias writes.
      issue(mfp_pkg::OP_WEIGHT, 0, 0, 0, 16'h1234, 1);
      issue(mfp_pkg::OP_BIAS, 0, 1, 0, 16'h4321, 1);
      issue(OP_RESERVED, 2, 15, 15, 16'hFFFF, 1);
      // Entries beyond the configured widths are stored but not used.
      issue(mfp_pkg::OP_WEIGHT, 3, 15, 15, 16'hA5A5, 1);
      issue(mfp_pkg::OP_ACT, 0, 15, 0, 16'h8000, 0);

      // A sum of exactly zero, then a fraction that is truncated.
      issue(mfp_pkg::OP_BIAS, 1, 0, 0, 16'h0000, 0);
      issue(mfp_pkg::OP_BIAS, 1, 1, 0, 16'h1000, 0);
      issue(mfp_pkg::OP_WEIGHT, 1, 0, 0, 16'h0800, 0);
      issue(mfp_pkg::OP_WEIGHT, 1, 0, 1, 16'hF800, 0);
      issue(mfp_pkg::OP_WEIGHT, 1, 1, 0, 16'h0001, 0);
      issue(mfp_pkg::OP_WEIGHT, 1, 1, 1, 16'h0003, 0);
      issue(mfp_pkg::OP_ACT, 0, 0, 0, 16'h0000, 0);
      issue(mfp_pkg::OP_ACT, 0, 1, 0, 16'h0000, 1);
      issue(mfp_pkg::OP_ACT, 0, 0, 0, 16'h2000, 0);
      issue(mfp_pkg::OP_ACT, 0, 1, 0, 16'h1001, 1);

      // Random phases over several layer settings; the first runs with
      // back-to-back requests only.
      idle_enabled = 1'b0;
      configure(5'd3, 5'd4, 5'd3, 5'd5, 5'd16);
      random_items(30);
      idle_enabled = 1'b1;
      configure(5'd0, 5'd0, 5'd1, 5'd1, 5'd1);
      random_items(15);
      configure(5'd4, 5'd0, 5'd1, 5'd0, 5'd1);
      random_items(15);
      configure(5'd7, 5'd3, 5'd2, 5'd4, 5'd3);
      random_items(25);
      configure(5'd2, 5'd1, 5'd16, 5'd31, 5'd16);
      random_items(15);
      configure(5'd4, 5'd3, 5'd4, 5'd2, 5'd16);
      random_items(20);
      configure(5'd1, 5'd17, 5'd1, 5'd0, 5'd5);
      random_items(15);

      settle();
      if (pending_count != 0)
         $display("%0t: %0d expected results never arrived", $time, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== mlp_forward_pass_relu_core.f =====
rtl/mfp_pkg.sv
rtl/mfp_store.sv
rtl/mfp_mac.sv
rtl/mfp_seq.sv
rtl/mlp_forward_pass_relu_core.sv
tb/sv/mlp_forward_pass_relu_checker.sv
tb/sv/mlp_forward_pass_relu_core_tb.sv
